// File: src/grid_line_of_sight_walker_unit_macros.svh
// Assertion helpers shared by the checker files of the line-of-sight walker.
// Each macro samples on the rising edge of i_clk and is switched off while
// i_rst_n is low, so the file that uses them must have both names in scope.
`ifndef GRID_LINE_OF_SIGHT_WALKER_UNIT_MACROS_SVH
`define GRID_LINE_OF_SIGHT_WALKER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GLOSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GLOSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/glosw_pkg.sv
`default_nettype none

package glosw_pkg;

    localparam int MAX_SIDE_DEF = 256;
    localparam int COORD_W      = 8;
    localparam int OP_W         = 2;
    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 1;
    // Walk positions may step one cell outside the 8-bit range on either side.
    localparam int POS_W        = COORD_W + 2;
    localparam int ERR_W        = COORD_W + 4;

    localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE      = 2'd0,
        OP_LINE_CLEAR = 2'd1,
        OP_FIRST_OPEN = 2'd2
    } t_op;

    // Which cell of the current step is being probed.
    typedef enum logic [1:0] {
        PROBE_MAIN,
        PROBE_SIDE,
        PROBE_OTHER
    } t_probe;

    typedef struct packed {
        logic   clear_row;
        logic   write_cell;
        logic   load;
        logic   issue;
        t_probe kind;
        logic   advance;
        logic   mark_hit;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic len_zero;
        logic last_step;
        logic err_nonneg;
        logic hit;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: src/glosw_in_if.sv
`default_nettype none

interface glosw_in_if;
    logic                          valid;
    logic                          ready;
    logic [glosw_pkg::OP_W-1:0]    op;
    logic [glosw_pkg::COORD_W-1:0] start_x;
    logic [glosw_pkg::COORD_W-1:0] start_y;
    logic [glosw_pkg::COORD_W-1:0] end_x;
    logic [glosw_pkg::COORD_W-1:0] end_y;
    logic                          blocked_value;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y, blocked_value,
        input  ready
    );
    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y, blocked_value,
        output ready
    );
endinterface

`default_nettype wire

// File: src/glosw_out_if.sv
`default_nettype none

interface glosw_out_if;
    logic                          valid;
    logic                          ready;
    logic                          line_clear;
    logic                          found;
    logic [glosw_pkg::COORD_W-1:0] found_x;
    logic [glosw_pkg::COORD_W-1:0] found_y;

    modport source (
        output valid, line_clear, found, found_x, found_y,
        input  ready
    );
    modport sink (
        input  valid, line_clear, found, found_x, found_y,
        output ready
    );
endinterface

`default_nettype wire

// File: src/glosw_ctrl.sv
`default_nettype none

module glosw_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [glosw_pkg::OP_W-1:0] i_op,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output glosw_pkg::t_dp_cmd              o_cmd,
    input  wire glosw_pkg::t_dp_sts         i_sts
);
    import glosw_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_ISSUE,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    t_probe r_kind, n_kind;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   step_done;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_acc     = i_in_valid && o_in_ready;

        o_cmd            = '0;
        o_cmd.kind       = r_kind;
        o_cmd.clear_row  = (r_state == S_CLEAR);
        o_cmd.write_cell = in_acc && (i_op == OP_WRITE);
        o_cmd.load       = in_acc && ((i_op == OP_LINE_CLEAR) || (i_op == OP_FIRST_OPEN));
        o_cmd.issue      = (r_state == S_ISSUE);

        n_state   = r_state;
        n_kind    = r_kind;
        step_done = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_kind  = PROBE_MAIN;
                n_state = i_sts.len_zero ? S_FINISH : S_ISSUE;
            end
            S_ISSUE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    o_cmd.mark_hit = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    unique case (r_kind)
                        PROBE_MAIN: begin
                            if (i_sts.err_nonneg) begin
                                n_kind  = PROBE_SIDE;
                                n_state = S_ISSUE;
                            end else begin
                                step_done = 1'b1;
                            end
                        end
                        PROBE_SIDE: begin
                            n_kind  = PROBE_OTHER;
                            n_state = S_ISSUE;
                        end
                        default: begin
                            step_done = 1'b1;
                        end
                    endcase
                    if (step_done) begin
                        o_cmd.advance = 1'b1;
                        n_kind        = PROBE_MAIN;
                        n_state       = i_sts.last_step ? S_FINISH : S_ISSUE;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_kind      <= PROBE_MAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/glosw_dp.sv
`default_nettype none

module glosw_dp #(
    parameter int MAX_SIDE = glosw_pkg::MAX_SIDE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire glosw_pkg::t_dp_cmd              i_cmd,
    output glosw_pkg::t_dp_sts                   o_sts,
    input  wire logic [glosw_pkg::OP_W-1:0]      i_op,
    input  wire logic [glosw_pkg::COORD_W-1:0]   i_start_x,
    input  wire logic [glosw_pkg::COORD_W-1:0]   i_start_y,
    input  wire logic [glosw_pkg::COORD_W-1:0]   i_end_x,
    input  wire logic [glosw_pkg::COORD_W-1:0]   i_end_y,
    input  wire logic                            i_blocked_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [glosw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [glosw_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                                 o_line_clear,
    output logic                                 o_found,
    output logic [glosw_pkg::COORD_W-1:0]        o_found_x,
    output logic [glosw_pkg::COORD_W-1:0]        o_found_y
);
    import glosw_pkg::*;

    localparam int          AW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam logic [31:0] SIDE_U = 32'(MAX_SIDE);

    // Blocked map: one row per y, one bit per x.
    logic [MAX_SIDE-1:0] mem [MAX_SIDE];

    logic [CFG_W-1:0]          r_grid_w, r_grid_h;
    logic [AW-1:0]             r_clr_row;
    logic signed [POS_W-1:0]   r_x, r_y;
    logic signed [1:0]         r_stx, r_sty;
    logic                      r_on_y;
    logic signed [ERR_W-1:0]   r_err;
    logic [COORD_W:0]          r_len2, r_min2;
    logic [COORD_W-1:0]        r_left;
    logic                      r_want_open;
    logic                      r_hit;
    logic signed [POS_W-1:0]   r_probe_x, r_probe_y;
    logic                      r_in_range;
    logic                      r_rd_bit;
    logic                      r_line_clear, r_found;
    logic [COORD_W-1:0]        r_found_x, r_found_y;

    // Set-up of a query from the input payload.
    logic signed [POS_W-1:0]   ld_dx, ld_dy;
    logic [COORD_W-1:0]        ld_adx, ld_ady, ld_len, ld_min;
    logic                      ld_on_y;
    logic signed [1:0]         ld_stx, ld_sty;
    logic signed [ERR_W-1:0]   ld_err;

    always_comb begin
        ld_dx   = $signed({2'b00, i_end_x}) - $signed({2'b00, i_start_x});
        ld_dy   = $signed({2'b00, i_end_y}) - $signed({2'b00, i_start_y});
        ld_adx  = ld_dx[POS_W-1] ? COORD_W'(-ld_dx) : ld_dx[COORD_W-1:0];
        ld_ady  = ld_dy[POS_W-1] ? COORD_W'(-ld_dy) : ld_dy[COORD_W-1:0];
        ld_stx  = (ld_dx == '0) ? 2'sb00 : (ld_dx[POS_W-1] ? 2'sb11 : 2'sb01);
        ld_sty  = (ld_dy == '0) ? 2'sb00 : (ld_dy[POS_W-1] ? 2'sb11 : 2'sb01);
        ld_on_y = (ld_ady > ld_adx);
        ld_len  = ld_on_y ? ld_ady : ld_adx;
        ld_min  = ld_on_y ? ld_adx : ld_ady;
        ld_err  = $signed({3'b000, ld_min, 1'b0}) - $signed({4'b0000, ld_len});
    end

    // Probe address for the current kind of cell.
    logic signed [POS_W-1:0] stx_e, sty_e, p_x, p_y;
    logic                    p_in_range;

    always_comb begin
        stx_e = POS_W'(r_stx);
        sty_e = POS_W'(r_sty);
        p_x   = r_x;
        p_y   = r_y;
        case (i_cmd.kind)
            PROBE_SIDE: begin
                if (r_on_y) begin
                    p_y = r_y + sty_e;
                end else begin
                    p_x = r_x + stx_e;
                end
            end
            PROBE_OTHER: begin
                if (r_on_y) begin
                    p_x = r_x + stx_e;
                end else begin
                    p_y = r_y + sty_e;
                end
            end
            default: begin
                p_x = r_x;
                p_y = r_y;
            end
        endcase
        p_in_range = !p_x[POS_W-1] && !p_y[POS_W-1]
                     && ($unsigned(p_x) < {1'b0, r_grid_w})
                     && ($unsigned(p_y) < {1'b0, r_grid_h})
                     && (32'($unsigned(p_x)) < SIDE_U)
                     && (32'($unsigned(p_y)) < SIDE_U);
    end

    // One major-axis step, with the minor move where the error term allows it.
    logic                    err_nonneg;
    logic signed [POS_W-1:0] adv_x, adv_y;
    logic signed [ERR_W-1:0] adv_err;

    always_comb begin
        err_nonneg = !r_err[ERR_W-1];
        adv_x      = r_x + ((r_on_y && !err_nonneg) ? '0 : stx_e);
        adv_y      = r_y + ((!r_on_y && !err_nonneg) ? '0 : sty_e);
        adv_err    = r_err + $signed({3'b000, r_min2})
                     - (err_nonneg ? $signed({3'b000, r_len2}) : '0);
    end

    logic wr_in_map;
    assign wr_in_map = (32'(i_start_x) < SIDE_U) && (32'(i_start_y) < SIDE_U);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_row) begin
            mem[r_clr_row] <= '0;
        end else if (i_cmd.write_cell && wr_in_map) begin
            mem[AW'(i_start_y)][AW'(i_start_x)] <= i_blocked_value;
        end
        if (i_cmd.issue) begin
            r_rd_bit <= mem[AW'(p_y)][AW'(p_x)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w  <= GRID_RESET;
            r_grid_h  <= GRID_RESET;
            r_clr_row <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                    CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear_row) begin
                r_clr_row <= r_clr_row + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x         <= $signed({2'b00, i_start_x});
            r_y         <= $signed({2'b00, i_start_y});
            r_stx       <= ld_stx;
            r_sty       <= ld_sty;
            r_on_y      <= ld_on_y;
            r_err       <= ld_err;
            r_len2      <= {ld_len, 1'b0};
            r_min2      <= {ld_min, 1'b0};
            r_left      <= ld_len;
            r_want_open <= (i_op == OP_FIRST_OPEN);
            // Equal endpoints in first-open mode report the start cell.
            r_hit       <= (i_op == OP_FIRST_OPEN) && (i_start_x == i_end_x)
                           && (i_start_y == i_end_y);
            r_probe_x   <= $signed({2'b00, i_start_x});
            r_probe_y   <= $signed({2'b00, i_start_y});
        end
        if (i_cmd.issue) begin
            r_probe_x  <= p_x;
            r_probe_y  <= p_y;
            r_in_range <= p_in_range;
        end
        if (i_cmd.mark_hit) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.advance) begin
            r_x    <= adv_x;
            r_y    <= adv_y;
            r_err  <= adv_err;
            r_left <= r_left - COORD_W'(1);
        end
        if (i_cmd.load_out) begin
            r_line_clear <= !r_want_open && !r_hit;
            r_found      <= r_want_open && r_hit;
            r_found_x    <= (r_want_open && r_hit) ? r_probe_x[COORD_W-1:0] : '0;
            r_found_y    <= (r_want_open && r_hit) ? r_probe_y[COORD_W-1:0] : '0;
        end
    end

    always_comb begin
        o_sts.clear_last = (r_clr_row == AW'(MAX_SIDE - 1));
        o_sts.len_zero   = (r_left == '0);
        o_sts.last_step  = (r_left == COORD_W'(1));
        o_sts.err_nonneg = err_nonneg;
        o_sts.hit        = ((r_in_range && !r_rd_bit) == r_want_open);
    end

    assign o_line_clear = r_line_clear;
    assign o_found      = r_found;
    assign o_found_x    = r_found_x;
    assign o_found_y    = r_found_y;

endmodule

`default_nettype wire

// File: src/grid_line_of_sight_walker_unit.sv
// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   op, start_x, start_y, end_x, end_y, blocked_value
// o_out     out  valid/ready   line_clear, found, found_x, found_y
// i_cfg_*   in   write enable  i_cfg_idx selects grid_width (0) or grid_height (1)
//
// After reset the blocked map is swept clear one row per cycle over all MAX_SIDE rows; no
// input transfer is taken until the sweep ends, configuration writes are. A cell write is
// stored as it is taken and leaves the block idle. A query passes through acceptance and
// set-up, the walk and wrap-up; each probed cell needs a map read, then an evaluation, with
// one or three probes per major-axis step, all through the single map read port.
// A finished result waits in the output register; a stalled sink holds the next query only.
`default_nettype none

module grid_line_of_sight_walker_unit #(
    parameter int MAX_SIDE = glosw_pkg::MAX_SIDE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    glosw_in_if.sink                             i_in,
    glosw_out_if.source                          o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [glosw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [glosw_pkg::CFG_W-1:0]     i_cfg_data
);
    import glosw_pkg::*;

    // The controller sequences the walk; the datapath holds the map, the
    // position and error term of the line, and the result register.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    glosw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.op),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    glosw_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_op            (i_in.op),
        .i_start_x       (i_in.start_x),
        .i_start_y       (i_in.start_y),
        .i_end_x         (i_in.end_x),
        .i_end_y         (i_in.end_y),
        .i_blocked_value (i_in.blocked_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_line_clear    (o_out.line_clear),
        .o_found         (o_out.found),
        .o_found_x       (o_out.found_x),
        .o_found_y       (o_out.found_y)
    );

endmodule

`default_nettype wire

// File: src/glosw_chk.sv
`default_nettype none
`include "grid_line_of_sight_walker_unit_macros.svh"

module glosw_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_line_clear,
    input wire logic                          i_found,
    input wire logic [glosw_pkg::COORD_W-1:0] i_found_x,
    input wire logic [glosw_pkg::COORD_W-1:0] i_found_y
);

    // A result held against a stalled sink keeps its value.
    `GLOSW_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_line_clear) && $stable(i_found) && $stable(i_found_x) && $stable(i_found_y), "result changed while stalled")

    // A result belongs to one mode only.
    `GLOSW_ASSERT_NOW(a_mode_excl, i_out_valid, !(i_line_clear && i_found), "line_clear and found both set")

    // A miss reports the origin.
    `GLOSW_ASSERT_NOW(a_miss_zero, i_out_valid && !i_found, (i_found_x == '0) && (i_found_y == '0), "coordinates set without a find")

    // A result is produced while the block is busy, never in the idle cycle.
    `GLOSW_ASSERT_NOW(a_out_busy, $rose(i_out_valid), !$past(i_in_ready), "result appeared while idle")

endmodule

bind grid_line_of_sight_walker_unit glosw_chk u_glosw_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_line_clear (o_out.line_clear),
    .i_found      (o_out.found),
    .i_found_x    (o_out.found_x),
    .i_found_y    (o_out.found_y)
);

`default_nettype wire

// File: tb/grid_line_of_sight_walker_unit_tb.sv
`timescale 1ns / 100ps

module grid_line_of_sight_walker_unit_tb;
    import glosw_pkg::*;

    // Geometry of the map and a bound on the walk of the longest line.
    localparam int SIDE             = MAX_SIDE_DEF;
    localparam int QUERY_MAX_CYCLES = 6 * 255 + 3;
    // Cell writes and the unused operation finish as they are taken, so this
    // margin covers any work still under way once the last result has arrived.
    localparam int CFG_SETTLE       = 16;
    // The long receiver hold-off starts once this many transfers have been taken.
    localparam int HOLD_AT          = 950;
    localparam int HOLD_CYCLES      = 3000;
    localparam int LIMIT_CYCLES     = 1300 * (QUERY_MAX_CYCLES + 64) * 4 + SIDE + HOLD_CYCLES;

    // The operation code that the block must ignore without a result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               blocked_value;
    } t_request;

    typedef struct packed {
        logic               line_clear;
        logic               found;
        logic [COORD_W-1:0] found_x;
        logic [COORD_W-1:0] found_y;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    glosw_in_if  in_ch ();
    glosw_out_if out_ch ();

    grid_line_of_sight_walker_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // The testbench's own picture of the block: the blocked map and the two
    // grid dimensions, both as they stand after reset.
    bit               map_blocked [SIDE*SIDE];
    logic [CFG_W-1:0] grid_w = GRID_RESET;
    logic [CFG_W-1:0] grid_h = GRID_RESET;

    t_request queued_requests [$];
    t_answer  due_answers [$];
    t_request in_flight;

    int send_idle_pct;
    int recv_idle_pct;
    int requests_taken = 0;
    int fault_count    = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit in_took        = 1'b0;
    bit sender_busy    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A cell counts as open only inside the configured grid and the map, and
    // only while its map bit is clear.
    function automatic bit cell_open(input int cx, input int cy);
        if (cx < 0 || cy < 0)
            return 1'b0;
        if (cx >= int'(grid_w) || cy >= int'(grid_h))
            return 1'b0;
        if (cx >= SIDE || cy >= SIDE)
            return 1'b0;
        return !map_blocked[cy * SIDE + cx];
    endfunction

    // Walks the Bresenham line from the start cell toward the target along the
    // major axis. Where the error term is non-negative the two corner cells of
    // the diagonal step are probed as well. The walk stops at the first probed
    // cell whose openness equals want_open and hands back its position. The
    // target cell itself is never probed as the main cell of a step.
    function automatic bit walk_line(input int x0, input int y0, input int tx, input int ty,
                                     input bit want_open, output int hx, output int hy);
        int x, y, dx, dy, sx, sy, err, t, i;
        bit steep;
        x     = x0;
        y     = y0;
        dx    = tx - x0;
        dy    = ty - y0;
        sx    = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy    = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        hx    = 0;
        hy    = 0;
        steep = 1'b0;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dy > dx) begin
            t     = dx;
            dx    = dy;
            dy    = t;
            steep = 1'b1;
        end
        err = 2 * dy - dx;
        for (i = 1; i <= dx; i++) begin
            if (cell_open(x, y) == want_open) begin
                hx = x;
                hy = y;
                return 1'b1;
            end
            if (err >= 0) begin
                if (steep) begin
                    if (cell_open(x, y + sy) == want_open) begin
                        hx = x;
                        hy = y + sy;
                        return 1'b1;
                    end
                    x += sx;
                end else begin
                    if (cell_open(x + sx, y) == want_open) begin
                        hx = x + sx;
                        hy = y;
                        return 1'b1;
                    end
                    y += sy;
                end
                if (cell_open(x, y) == want_open) begin
                    hx = x;
                    hy = y;
                    return 1'b1;
                end
                err -= 2 * dx;
            end
            if (steep)
                y += sy;
            else
                x += sx;
            err += 2 * dy;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fault_count++;
        end
    endfunction

    // Grid dimensions for a run: often the full side, sometimes a single
    // column or row, otherwise anything in between.
    function automatic logic [CFG_W-1:0] pick_side();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return CFG_W'(SIDE);
        if (roll < 30)
            return CFG_W'(1);
        return CFG_W'($urandom_range(SIDE, 1));
    endfunction

    // Corner of a working window: mostly inside the configured grid, so that
    // the walks meet stored cells, and now and then anywhere on the map.
    function automatic logic [COORD_W-1:0] pick_base(input logic [CFG_W-1:0] extent);
        if (extent == 0 || $urandom_range(4) == 0)
            return COORD_W'($urandom_range(SIDE - 1));
        return COORD_W'($urandom_range(int'(extent) - 1));
    endfunction

    task automatic queue_request(input logic [OP_W-1:0] op,
                                 input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                 input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                                 input logic bv);
        t_request item;
        item = '{op: op, start_x: sx, start_y: sy, end_x: ex, end_y: ey, blocked_value: bv};
        queued_requests.insert(queued_requests.size(), item);
    endtask

    // Returns once every queued request has been transferred and every awaited
    // result has come back. The input valid and the queue change only on the
    // falling edge, so sampling them here is free of races.
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (queued_requests.size() != 0 || in_ch.valid || due_answers.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_GRID_WIDTH)
            grid_w = value;
        else
            grid_h = value;
    endtask

    // Registers are only touched while the block is idle, so the sender first
    // waits until every result of the previous run has come back.
    task automatic configure_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_drained();
        repeat (CFG_SETTLE) @(posedge i_clk);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
    endtask

    // Random traffic is clustered in small windows, so that cell writes build
    // up walls and gaps that the queries then run into. A few queries span the
    // whole map to reach every coordinate bit, and a sprinkling of unused
    // operation codes checks that they are ignored.
    task automatic queue_random_run(input int count);
        int made, roll, span;
        logic [COORD_W-1:0] bx, by;
        logic [OP_W-1:0]    qop;
        made = 0;
        span = 8;
        bx   = '0;
        by   = '0;
        while (made < count) begin
            if (made % 48 == 0) begin
                bx   = pick_base(grid_w);
                by   = pick_base(grid_h);
                roll = $urandom_range(99);
                span = (roll < 50) ? 4 : (roll < 80) ? 8 : (roll < 95) ? 16 : 64;
            end
            roll = $urandom_range(99);
            qop  = $urandom_range(1) ? OP_LINE_CLEAR : OP_FIRST_OPEN;
            if (roll < 3) begin
                queue_request(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
                              COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
            end else begin
                made++;
                if (roll < 40)
                    queue_request(OP_WRITE, COORD_W'(bx + $urandom_range(span - 1)),
                                  COORD_W'(by + $urandom_range(span - 1)),
                                  COORD_W'($urandom), COORD_W'($urandom),
                                  $urandom_range(99) < 45);
                else if (roll < 45)
                    queue_request(qop, COORD_W'($urandom), COORD_W'($urandom),
                                  COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
                else
                    queue_request(qop, COORD_W'(bx + $urandom_range(span - 1)),
                                  COORD_W'(by + $urandom_range(span - 1)),
                                  COORD_W'(bx + $urandom_range(span - 1)),
                                  COORD_W'(by + $urandom_range(span - 1)), 1'($urandom));
            end
        end
    endtask

    // Request driver. A request stays on the channel until its transfer has
    // been seen on a rising edge; new requests are offered on the falling edge
    // unless the sender decides to idle for the cycle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sender_busy = 1'b0;
            in_ch.valid <= 1'b0;
        end else begin
            if (in_took)
                sender_busy = 1'b0;
            if (!sender_busy && queued_requests.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                in_flight   = queued_requests.pop_front();
                sender_busy = 1'b1;
                in_ch.op            <= in_flight.op;
                in_ch.start_x       <= in_flight.start_x;
                in_ch.start_y       <= in_flight.start_y;
                in_ch.end_x         <= in_flight.end_x;
                in_ch.end_y         <= in_flight.end_y;
                in_ch.blocked_value <= in_flight.blocked_value;
            end
            in_ch.valid <= sender_busy;
        end
    end

    // Result receiver. Besides idling at random it once holds off for a long
    // stretch, counted here, while the sender keeps offering requests, so that
    // the output register fills and the block has to stall its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && requests_taken >= HOLD_AT) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Request monitor and predictor. Requests are handled strictly in order,
    // so each transfer but an unused code is applied to the map or answered at
    // once, and its answer joins the back of the queue of results to come.
    always @(posedge i_clk) begin : request_monitor
        t_request req;
        t_answer  ans;
        int       hx, hy;
        bit       same, hit;
        in_took <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            req = '{op: in_ch.op, start_x: in_ch.start_x, start_y: in_ch.start_y,
                    end_x: in_ch.end_x, end_y: in_ch.end_y,
                    blocked_value: in_ch.blocked_value};
            requests_taken++;
            ans  = '0;
            hx   = 0;
            hy   = 0;
            same = (req.start_x == req.end_x) && (req.start_y == req.end_y);
            case (req.op)
                OP_WRITE: begin
                    // Cells outside the configured grid are stored all the same.
                    map_blocked[{req.start_y, req.start_x}] = req.blocked_value;
                end
                OP_LINE_CLEAR: begin
                    // A line from a cell to itself is clear even if that cell is blocked.
                    ans.line_clear = same || !walk_line(req.start_x, req.start_y, req.end_x,
                                                        req.end_y, 1'b0, hx, hy);
                    due_answers.insert(due_answers.size(), ans);
                end
                OP_FIRST_OPEN: begin
                    // Equal endpoints report the start cell, open or not.
                    if (same) begin
                        hit = 1'b1;
                        hx  = req.start_x;
                        hy  = req.start_y;
                    end else begin
                        hit = walk_line(req.start_x, req.start_y, req.end_x, req.end_y,
                                        1'b1, hx, hy);
                    end
                    ans.found = hit;
                    if (hit) begin
                        ans.found_x = hx[COORD_W-1:0];
                        ans.found_y = hy[COORD_W-1:0];
                    end
                    due_answers.insert(due_answers.size(), ans);
                end
                default: begin
                    // The unused operation code leaves everything as it was.
                end
            endcase
        end
    end

    // Result monitor: every result transfer is checked field by field against
    // the oldest answer still awaited.
    always @(posedge i_clk) begin : answer_monitor
        t_answer want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_answers.size() == 0) begin
                $display("%0t: result with none awaited, actual line_clear %0d found %0d (%0d,%0d)",
                         $time, out_ch.line_clear, out_ch.found, out_ch.found_x, out_ch.found_y);
                fault_count++;
            end else begin
                want = due_answers.pop_front();
                check_field("line_clear", want.line_clear, out_ch.line_clear);
                check_field("found", want.found, out_ch.found);
                check_field("found_x", want.found_x, out_ch.found_x);
                check_field("found_y", want.found_y, out_ch.found_y);
            end
        end
    end

    // Watchdog: the limit allows every item the longest walk, the worst gaps
    // on both sides, the clearing sweep after reset and the long hold-off.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("grid_line_of_sight_walker_unit regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.op            = OP_WRITE;
        in_ch.start_x       = '0;
        in_ch.start_y       = '0;
        in_ch.end_x         = '0;
        in_ch.end_y         = '0;
        in_ch.blocked_value = 1'b0;
        out_ch.ready        = 1'b0;
        send_idle_pct       = 16;
        recv_idle_pct       = 87;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers may be written while the map is still being swept clear.
        configure_grid(GRID_RESET, GRID_RESET);

        // Directed requests on the full grid. The first two walk the longest
        // diagonals of an empty map; then blocked corners are used to show that
        // equal endpoints still report clear or the start cell, and that the
        // target cell is never probed.
        queue_request(OP_LINE_CLEAR, 8'd0,   8'd0,   8'd255, 8'd255, 1'b0);
        queue_request(OP_FIRST_OPEN, 8'd255, 8'd0,   8'd0,   8'd255, 1'b1);
        queue_request(OP_WRITE,      8'd255, 8'd255, 8'd0,   8'd0,   1'b1);
        queue_request(OP_WRITE,      8'd0,   8'd0,   8'd255, 8'd255, 1'b1);
        queue_request(OP_LINE_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        queue_request(OP_FIRST_OPEN, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        queue_request(OP_LINE_CLEAR, 8'd0,   8'd0,   8'd10,  8'd3,   1'b0);
        queue_request(OP_FIRST_OPEN, 8'd0,   8'd0,   8'd10,  8'd3,   1'b0);
        queue_request(OP_LINE_CLEAR, 8'd254, 8'd254, 8'd255, 8'd255, 1'b0);
        queue_request(OP_FIRST_OPEN, 8'd255, 8'd255, 8'd254, 8'd254, 1'b0);
        // A blocked corner cell beside a shallow line, then a steep line.
        queue_request(OP_WRITE,      8'd121, 8'd60,  8'd0,   8'd0,   1'b1);
        queue_request(OP_LINE_CLEAR, 8'd120, 8'd60,  8'd130, 8'd65,  1'b0);
        queue_request(OP_LINE_CLEAR, 8'd60,  8'd120, 8'd65,  8'd130, 1'b0);
        queue_request(OP_WRITE,      8'd121, 8'd60,  8'd0,   8'd0,   1'b0);
        // A short wall walked from either side.
        queue_request(OP_WRITE,      8'd50,  8'd50,  8'd0,   8'd0,   1'b1);
        queue_request(OP_WRITE,      8'd51,  8'd50,  8'd0,   8'd0,   1'b1);
        queue_request(OP_FIRST_OPEN, 8'd50,  8'd50,  8'd60,  8'd50,  1'b0);
        queue_request(OP_FIRST_OPEN, 8'd51,  8'd50,  8'd40,  8'd50,  1'b0);
        queue_request(OP_UNUSED,     8'd255, 8'd255, 8'd255, 8'd255, 1'b1);

        // A single column: everything right of it is blocked, and a cell
        // written out there is kept for later.
        configure_grid(CFG_W'(1), CFG_W'(SIDE));
        queue_request(OP_LINE_CLEAR, 8'd0,   8'd0,   8'd0,   8'd200, 1'b0);
        queue_request(OP_FIRST_OPEN, 8'd3,   8'd5,   8'd0,   8'd5,   1'b0);
        queue_request(OP_WRITE,      8'd200, 8'd3,   8'd0,   8'd0,   1'b1);

        // Zero width: every cell counts as blocked.
        configure_grid(CFG_W'(0), CFG_W'(SIDE));
        queue_request(OP_LINE_CLEAR, 8'd1,   8'd1,   8'd2,   8'd2,   1'b0);
        queue_request(OP_FIRST_OPEN, 8'd7,   8'd7,   8'd7,   8'd7,   1'b0);

        // A single row, then the full grid again, where the cell stored while
        // out of range now blocks a line.
        configure_grid(CFG_W'(SIDE), CFG_W'(1));
        queue_request(OP_LINE_CLEAR, 8'd0,   8'd0,   8'd255, 8'd0,   1'b0);
        configure_grid(CFG_W'(SIDE), CFG_W'(SIDE));
        queue_request(OP_LINE_CLEAR, 8'd195, 8'd0,   8'd205, 8'd6,   1'b0);

        // Random runs: first a fast sender against a mostly stalled receiver,
        // then the other way round, then both at full rate. Each run sets a
        // fresh grid size once the previous one has drained.
        configure_grid(CFG_W'(SIDE), pick_side());
        queue_random_run(185);
        configure_grid(pick_side(), CFG_W'(SIDE));
        queue_random_run(185);

        configure_grid(pick_side(), pick_side());
        send_idle_pct = 87;
        recv_idle_pct = 16;
        queue_random_run(185);
        configure_grid(pick_side(), pick_side());
        queue_random_run(185);

        configure_grid(pick_side(), pick_side());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_run(185);
        configure_grid(CFG_W'(SIDE), CFG_W'(SIDE));
        queue_random_run(185);

        // Let any stray result show itself before the verdict.
        wait_drained();
        repeat (QUERY_MAX_CYCLES + CFG_SETTLE) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("grid_line_of_sight_walker_unit regression: pass");
        end else begin
            $display("grid_line_of_sight_walker_unit regression: fail");
        end
        $finish;
    end

endmodule
